>>> sv/assert_macros.svh
// assertion helpers used by tvp_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> sv/tvp_pkg.sv
package tvp_pkg;

    typedef enum logic [2:0] {
        EV_VARINT    = 3'd0,
        EV_BYTE      = 3'd1,
        EV_LENGTH    = 3'd2,
        EV_PAYLOAD   = 3'd3,
        EV_BAD_TAG   = 3'd4,
        EV_TOO_LONG  = 3'd5,
        EV_TOO_LARGE = 3'd6
    } ev_kind_t;

    // length-delimited tags
    localparam logic [7:0] TAG_LD_A = 8'h0a;
    localparam logic [7:0] TAG_LD_B = 8'h2a;
    localparam logic [7:0] TAG_LD_C = 8'h32;
    localparam logic [7:0] TAG_LD_D = 8'h3a;
    // single raw byte tags
    localparam logic [7:0] TAG_BY_A = 8'h08;
    localparam logic [7:0] TAG_BY_B = 8'h10;
    // varint tags
    localparam logic [7:0] TAG_VI_A = 8'h18;
    localparam logic [7:0] TAG_VI_B = 8'h20;
    localparam logic [7:0] TAG_VI_C = 8'h28;

    localparam logic [3:0] MAX_VARINT_RESET = 4'd9;
    localparam logic [3:0] MAX_VARINT_CAP   = 4'd10;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       buffer_end;
    } item_t;

    typedef struct packed {
        ev_kind_t    kind;
        logic [7:0]  tag;
        logic [63:0] value;
        logic        last;
    } result_t;

endpackage

>>> sv/tvp_in_stage.sv
module tvp_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  tvp_pkg::item_t s_item,
    input  logic           advance,
    output logic           item_valid,
    output tvp_pkg::item_t item
);
    import tvp_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // slot frees when the held request moves on
    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

>>> sv/tvp_core.sv
`include "assert_macros.svh"

module tvp_core #(
    parameter int LEN_BITS = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [3:0]       cfg_wr_data,
    input  logic             step,
    input  tvp_pkg::item_t   item,
    output logic             res_valid,
    output tvp_pkg::result_t res
);
    import tvp_pkg::*;

    typedef enum logic [2:0] {
        M_TAG, M_LEN, M_VARINT, M_BYTE, M_PAYLOAD, M_HALT
    } mode_t;

    mode_t               mode_reg, mode_next;
    logic [7:0]          tag_reg, tag_next;
    logic [63:0]         acc_reg, acc_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic [LEN_BITS-1:0] rem_reg, rem_next;
    logic [3:0]          max_reg;

    logic [3:0]          limit;
    logic [3:0]          cnt_inc;
    logic [5:0]          shift_full;
    logic [63:0]         acc_or;
    logic [LEN_BITS-1:0] rem_dec;
    logic                too_large;

    assign limit      = (max_reg > MAX_VARINT_CAP) ? MAX_VARINT_CAP : max_reg;
    assign cnt_inc    = cnt_reg + 4'd1;
    // byte k of a varint lands at bit 7*k; high bits past 63 fall off
    assign shift_full = 6'(cnt_reg) * 6'd7;
    assign acc_or     = acc_reg | (64'(item.byte_in[6:0]) << shift_full);
    assign too_large  = acc_or[63:LEN_BITS] != '0;
    assign rem_dec    = rem_reg - LEN_BITS'(1);

    always_comb begin
        mode_next = mode_reg;
        tag_next  = tag_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        res_valid = 1'b0;
        res       = '{kind: EV_VARINT, tag: tag_reg, value: '0, last: 1'b0};

        unique case (mode_reg)
            M_TAG: begin
                acc_next = '0;
                cnt_next = '0;
                unique case (item.byte_in) inside
                    TAG_LD_A, TAG_LD_B, TAG_LD_C, TAG_LD_D: begin
                        tag_next  = item.byte_in;
                        mode_next = M_LEN;
                        res_valid = item.buffer_end;
                        res.kind  = EV_LENGTH;
                        res.tag   = item.byte_in;
                    end
                    TAG_BY_A, TAG_BY_B: begin
                        tag_next  = item.byte_in;
                        mode_next = M_BYTE;
                    end
                    TAG_VI_A, TAG_VI_B, TAG_VI_C: begin
                        tag_next  = item.byte_in;
                        mode_next = M_VARINT;
                        res_valid = item.buffer_end;
                        res.kind  = EV_VARINT;
                        res.tag   = item.byte_in;
                    end
                    default: begin
                        // unknown tag: report and halt, current tag kept
                        res_valid = 1'b1;
                        res.kind  = EV_BAD_TAG;
                        res.tag   = item.byte_in;
                        mode_next = M_HALT;
                    end
                endcase
            end
            M_LEN, M_VARINT: begin
                cnt_next = cnt_inc;
                if (cnt_inc > limit) begin
                    res_valid = 1'b1;
                    res.kind  = EV_TOO_LONG;
                    mode_next = M_HALT;
                end else begin
                    acc_next = acc_or;
                    if (!item.byte_in[7] || item.buffer_end) begin
                        res_valid = 1'b1;
                        res.value = acc_or;
                        if (mode_reg == M_VARINT) begin
                            res.kind  = EV_VARINT;
                            mode_next = M_TAG;
                        end else if (too_large) begin
                            res.kind  = EV_TOO_LARGE;
                            mode_next = M_HALT;
                        end else begin
                            res.kind  = EV_LENGTH;
                            rem_next  = acc_or[LEN_BITS-1:0];
                            mode_next = (acc_or[LEN_BITS-1:0] != '0) ? M_PAYLOAD : M_TAG;
                        end
                    end
                end
            end
            M_BYTE: begin
                res_valid = 1'b1;
                res.kind  = EV_BYTE;
                res.value = 64'(item.byte_in);
                mode_next = M_TAG;
            end
            M_PAYLOAD: begin
                rem_next  = rem_dec;
                res_valid = 1'b1;
                res.kind  = EV_PAYLOAD;
                res.value = 64'(item.byte_in);
                res.last  = (rem_dec == '0) || item.buffer_end;
                if (rem_dec == '0) begin
                    mode_next = M_TAG;
                end
            end
            M_HALT: begin
                // drop bytes until the buffer ends
            end
            default: begin
                mode_next = M_TAG;
            end
        endcase

        if (item.buffer_end) begin
            mode_next = M_TAG;
            acc_next  = '0;
            cnt_next  = '0;
            rem_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_TAG;
            tag_reg  <= '0;
            acc_reg  <= '0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            max_reg  <= MAX_VARINT_RESET;
        end else begin
            if (step) begin
                mode_reg <= mode_next;
                tag_reg  <= tag_next;
                acc_reg  <= acc_next;
                cnt_reg  <= cnt_next;
                rem_reg  <= rem_next;
            end
            if (cfg_wr_en) begin
                max_reg <= cfg_wr_data;
            end
        end
    end

    `ASSERT_IMPLIES(a_payload_nonzero, aclk, aresetn, mode_reg == M_PAYLOAD, rem_reg != '0)
    `ASSERT_IMPLIES(a_varint_count, aclk, aresetn,
        mode_reg == M_LEN || mode_reg == M_VARINT, cnt_reg <= MAX_VARINT_CAP)
    `ASSERT_IMPLIES(a_last_only_payload, aclk, aresetn,
        step && res_valid && res.last, res.kind == EV_PAYLOAD)
    `ASSERT_NEXT(a_end_clears, aclk, aresetn,
        step && item.buffer_end, mode_reg == M_TAG && acc_reg == '0)

endmodule

>>> sv/tvp_out_stage.sv
module tvp_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic             res_valid,
    input  tvp_pkg::result_t res,
    output logic             free,
    output logic             m_valid,
    input  logic             m_ready,
    output tvp_pkg::result_t m_res
);
    import tvp_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    // the register can take a new result when empty or draining this cycle
    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (step) begin
            valid_reg <= res_valid;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            res_reg <= res;
        end
    end

endmodule

>>> sv/tagged_varint_field_parser_top.sv
// tagged varint field parser, one buffer byte per request
// a byte is held in the input register until it is parsed, then its result is registered
// throughput: one byte per cycle while m_ready stays high, set by the single parse step
//   between the input register and the result register
// reset: synchronous active-low aresetn; parser expects a tag, limit is 9
module tagged_varint_field_parser_top #(
    parameter int LEN_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: longest varint accepted
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    // byte requests in
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    input  logic        s_buffer_end,
    // event requests out
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_kind,
    output logic [7:0]  m_field_tag,
    output logic [63:0] m_field_value,
    output logic        m_payload_last
);
    import tvp_pkg::*;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    out_free;
    logic    step;
    logic    res_valid;
    result_t res;
    result_t m_res;

    assign s_item = '{byte_in: s_byte_in, buffer_end: s_buffer_end};

    // the held byte is parsed when the result register has room; a result
    // waiting on the consumer holds the byte, which then holds off the next
    // request until the result drains
    assign step = item_valid && out_free;

    // input register
    tvp_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .advance   (step),
        .item_valid(item_valid),
        .item      (item)
    );

    // parser state and the one-step decode
    tvp_core #(
        .LEN_BITS(LEN_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .step       (step),
        .item       (item),
        .res_valid  (res_valid),
        .res        (res)
    );

    // result register toward the consumer
    tvp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .res_valid(res_valid),
        .res      (res),
        .free     (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (m_res)
    );

    assign m_event_kind   = 3'(m_res.kind);
    assign m_field_tag    = m_res.tag;
    assign m_field_value  = m_res.value;
    assign m_payload_last = m_res.last;

endmodule
